@@ rtl/sch_pkg.sv @@
// Package for the segmented CRC-32C name hash unit.
// Holds the CRC-32C byte update, the separator test, key constants and the
// struct handed from the accumulate stage to the key stage. No dependencies.
package sch_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned KEY_W  = 64;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] TOP_BIT  = 32'h8000_0000;
    localparam logic [15:0]      KEY_LOW  = 16'h8000;

    localparam logic [BYTE_W-1:0] SEP_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] SEP_DASH  = 8'h2D;
    localparam logic [BYTE_W-1:0] SEP_UNDER = 8'h5F;
    localparam logic [BYTE_W-1:0] SEP_TILDE = 8'h7E;

    // Everything the key stage needs once a name is complete.
    typedef struct packed {
        logic [CRC_W-1:0] sum;       // sum of the closed segment CRCs
        logic [CRC_W-1:0] seg_crc;   // CRC register of the still open segment
        logic             seg_ne;    // open segment holds at least one byte
        logic [CRC_W-1:0] whole_crc; // CRC register of the whole name
    } t_fin;

    // Reflected CRC-32C update by one byte, before any final inversion.
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic is_sep(input logic [BYTE_W-1:0] b);
        return (b == SEP_DOT) || (b == SEP_DASH) || (b == SEP_UNDER) || (b == SEP_TILDE);
    endfunction

endpackage

@@ rtl/sch_state.sv @@
// Accumulate stage of the name hash: per-byte CRC-32C updates of the open
// segment and the whole name, segment summing, and the completed-name register.
// Depends on sch_pkg.
module sch_state
    import sch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_move,     // byte in the input register advances
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic              i_fin_take, // key stage loads the completed name
    output logic              o_fin_valid,
    output t_fin              o_fin
);

    logic [CRC_W-1:0] r_seg_crc, n_seg_crc;
    logic             r_seg_ne,  n_seg_ne;
    logic [CRC_W-1:0] r_sum,     n_sum;
    logic [CRC_W-1:0] r_whole,   n_whole;
    logic             r_fin_valid, n_fin_valid;
    t_fin             r_fin;

    // A separator closes the open segment; its CRC joins the sum when it is
    // non-empty. Otherwise the byte extends the segment.
    always_comb begin
        n_whole = crc_byte(r_whole, i_byte);
        if (is_sep(i_byte)) begin
            n_seg_crc = CRC_INIT;
            n_seg_ne  = 1'b0;
            n_sum     = r_seg_ne ? (r_sum + ~r_seg_crc) : r_sum;
        end else begin
            n_seg_crc = crc_byte(r_seg_crc, i_byte);
            n_seg_ne  = 1'b1;
            n_sum     = r_sum;
        end
        n_fin_valid = (r_fin_valid && !i_fin_take) || (i_move && i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_crc   <= CRC_INIT;
            r_seg_ne    <= 1'b0;
            r_sum       <= '0;
            r_whole     <= CRC_INIT;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_fin_valid;
            if (i_move) begin
                if (i_last) begin
                    // Name done: the open segment is closed in the key stage.
                    r_seg_crc <= CRC_INIT;
                    r_seg_ne  <= 1'b0;
                    r_sum     <= '0;
                    r_whole   <= CRC_INIT;
                end else begin
                    r_seg_crc <= n_seg_crc;
                    r_seg_ne  <= n_seg_ne;
                    r_sum     <= n_sum;
                    r_whole   <= n_whole;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_move && i_last) begin
            r_fin.sum       <= n_sum;
            r_fin.seg_crc   <= n_seg_crc;
            r_fin.seg_ne    <= n_seg_ne;
            r_fin.whole_crc <= n_whole;
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin       = r_fin;

    // The last byte returns the running state to its start values.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_move && i_last |=> r_seg_crc == CRC_INIT && !r_seg_ne && r_sum == '0
                             && r_whole == CRC_INIT)
        else $error("state not restarted after last byte");

    // An empty open segment always carries the initial CRC.
    a_empty_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seg_ne |-> r_seg_crc == CRC_INIT)
        else $error("empty segment with modified CRC");

    // A completed name waiting for the key stage is neither lost nor altered.
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid && !i_fin_take |=> r_fin_valid && $stable(r_fin))
        else $error("pending completed name changed");

endmodule

@@ rtl/sch_key.sv @@
// Key stage of the name hash: closes the final segment, forms the 64-bit
// key and holds it in the result register. Depends on sch_pkg.
module sch_key
    import sch_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,  // completed name moves in
    input  t_fin             i_fin,
    input  logic             i_take,  // downstream ready
    output logic             o_free,  // result register can load this cycle
    output logic             o_valid,
    output logic [KEY_W-1:0] o_key
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key, n_key;
    logic [CRC_W-1:0] w_top;
    logic [CRC_W-1:0] w_whole;

    always_comb begin
        w_top   = (i_fin.sum + (i_fin.seg_ne ? ~i_fin.seg_crc : '0)) | TOP_BIT;
        w_whole = ~i_fin.whole_crc;
        n_key   = {w_top, w_whole[31:16] ^ w_whole[15:0], KEY_LOW};
    end

    assign o_free = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_key <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

    // Every key has its fixed bits: bit 63 and bit 15 set, bits 14..0 clear.
    a_fixed_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_key[KEY_W-1] && r_key[15:0] == KEY_LOW)
        else $error("key fixed bits wrong");

    // A load is only offered when the result register can take it.
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("completed name offered to a full result register");

endmodule

@@ rtl/segmented_crc_name_hash_unit.sv @@
// Top level of the segmented CRC-32C name hash unit.
// Instantiates sch_state and sch_key; depends on sch_pkg.
//
// The unit takes a name one byte per item on the slave stream, with tlast on
// the final byte, and returns one 64-bit directory key per name on the master
// stream. Bits 63..32 hold the modulo 2^32 sum of the CRC-32C of every
// non-empty segment, with bit 31 of that word forced to one; segments are cut
// at '.', '-', '_' and '~', which belong to no segment. Bits 31..16 hold the
// XOR of the two halves of the CRC-32C of the whole name, bit 15 is one and
// bits 14..0 are zero. CRC-32C is the iSCSI form (reflected polynomial
// 0x82F63B78, initial value all ones, final inversion). The unit accepts one
// byte every clock cycle while no last byte is held back; the rate is set by
// the byte-wide CRC update in the accumulate stage, which is a single XOR
// network. A byte passes an input register, then the accumulate stage and the
// key stage, whose result register drives the master side. Back-pressure on
// the master side stalls only the last byte of a name while a completed name
// waits, so other bytes of the next name keep flowing while a key waits.
module segmented_crc_name_hash_unit
    import sch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,  // [7:0] name_byte
    input  logic              i_s_tlast,  // last_byte
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [KEY_W-1:0]  o_m_tdata   // [63:0] hash_key
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic              w_in_move;
    logic              w_fin_valid;
    logic              w_fin_take;
    logic              w_key_free;
    t_fin              w_fin;

    // The last byte of a name may advance only when the completed-name
    // register has room; other bytes advance every cycle.
    assign w_fin_take = w_fin_valid && w_key_free;
    assign w_in_move  = r_in_valid && (!r_in_last || !w_fin_valid || w_key_free);
    assign o_s_tready = !r_in_valid || w_in_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    sch_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_move      (w_in_move),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_fin_take  (w_fin_take),
        .o_fin_valid (w_fin_valid),
        .o_fin       (w_fin)
    );

    sch_key u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_fin_take),
        .i_fin   (w_fin),
        .i_take  (i_m_tready),
        .o_free  (w_key_free),
        .o_valid (o_m_tvalid),
        .o_key   (o_m_tdata)
    );

endmodule
